FILE: rtl/ppcr_pkg.sv
// Shared types, constants and helpers for the disc pair collision resolver.
package ppcr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int RAD_W         = 30;
	localparam int BNC_W         = 17;
	localparam int SEP_W         = RAD_W + 1;
	localparam int SQ_IN_W       = 2 * SEP_W + 1;
	localparam int SQ_STAGES     = (SQ_IN_W + 1) / 2;
	localparam logic [BNC_W-1:0] BOUNCE_ONE = BNC_W'(65536);

	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_BOUNCE = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] first_pos_x;
		logic signed [DATA_W-1:0] first_pos_y;
		logic signed [DATA_W-1:0] first_vel_x;
		logic signed [DATA_W-1:0] first_vel_y;
		logic signed [DATA_W-1:0] second_pos_x;
		logic signed [DATA_W-1:0] second_pos_y;
		logic signed [DATA_W-1:0] second_vel_x;
		logic signed [DATA_W-1:0] second_vel_y;
	} pair_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] new_first_pos_x;
		logic signed [DATA_W-1:0] new_first_pos_y;
		logic signed [DATA_W-1:0] new_first_vel_x;
		logic signed [DATA_W-1:0] new_first_vel_y;
		logic signed [DATA_W-1:0] new_second_pos_x;
		logic signed [DATA_W-1:0] new_second_pos_y;
		logic signed [DATA_W-1:0] new_second_vel_x;
		logic signed [DATA_W-1:0] new_second_vel_y;
		logic                     overlapped;
		logic                     bounced;
	} result_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

FILE: rtl/ppcr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ppcr_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [ppcr_pkg::SQ_IN_W-1:0]      radicand,
	input  logic [SIDE_W-1:0]                 in_side,
	output logic                              out_vld,
	output logic [ppcr_pkg::SEP_W-1:0]        root,
	output logic [SIDE_W-1:0]                 out_side
);
	localparam int N  = ppcr_pkg::SQ_STAGES;
	localparam int XW = 2 * N;

	logic [XW-1:0]     x_s    [N+1];
	logic [XW-1:0]     r_s    [N+1];
	logic              vld_s  [N+1];
	logic [SIDE_W-1:0] side_s [N+1];

	assign x_s[0]    = XW'(radicand);
	assign r_s[0]    = '0;
	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * g);
		logic [XW-1:0] trial;
		assign trial = r_s[g] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			side_s[g+1] <= side_s[g];
			if (x_s[g] >= trial) begin
				x_s[g+1] <= x_s[g] - trial;
				r_s[g+1] <= (r_s[g] >> 1) + BIT;
			end else begin
				x_s[g+1] <= x_s[g];
				r_s[g+1] <= r_s[g] >> 1;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = r_s[N][ppcr_pkg::SEP_W-1:0];
	assign out_side = side_s[N];
endmodule

FILE: rtl/ppcr_div.sv
// Pipelined restoring divider, two numerators over one divisor, one quotient bit per stage.
module ppcr_div #(
	parameter int FRAC_BITS = ppcr_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [ppcr_pkg::SEP_W-1:0]    num_x,
	input  logic [ppcr_pkg::SEP_W-1:0]    num_y,
	input  logic [ppcr_pkg::SEP_W-1:0]    den,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output logic [FRAC_BITS:0]            quo_x,
	output logic [FRAC_BITS:0]            quo_y,
	output logic [SIDE_W-1:0]             out_side
);
	localparam int N  = FRAC_BITS + 1;
	localparam int DW = ppcr_pkg::SEP_W;
	localparam int RW = DW + FRAC_BITS + 1;

	logic [RW-1:0]      rx_s   [N+1];
	logic [RW-1:0]      ry_s   [N+1];
	logic [FRAC_BITS:0] qx_s   [N+1];
	logic [FRAC_BITS:0] qy_s   [N+1];
	logic [DW-1:0]      d_s    [N+1];
	logic               vld_s  [N+1];
	logic [SIDE_W-1:0]  side_s [N+1];

	assign rx_s[0]   = RW'(num_x) << FRAC_BITS;
	assign ry_s[0]   = RW'(num_y) << FRAC_BITS;
	assign qx_s[0]   = '0;
	assign qy_s[0]   = '0;
	assign d_s[0]    = den;
	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          gx;
		logic          gy;
		assign dsh = RW'(d_s[g]) << (FRAC_BITS - g);
		assign gx  = rx_s[g] >= dsh;
		assign gy  = ry_s[g] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			side_s[g+1] <= side_s[g];
			d_s[g+1]    <= d_s[g];
			rx_s[g+1]   <= gx ? rx_s[g] - dsh : rx_s[g];
			ry_s[g+1]   <= gy ? ry_s[g] - dsh : ry_s[g];
			qx_s[g+1]   <= {qx_s[g][FRAC_BITS-1:0], gx};
			qy_s[g+1]   <= {qy_s[g][FRAC_BITS-1:0], gy};
		end
	end

	assign out_vld  = vld_s[N];
	assign quo_x    = qx_s[N];
	assign quo_y    = qy_s[N];
	assign out_side = side_s[N];
endmodule

FILE: rtl/particle_pair_collision_resolve_unit.sv
// Top level of the disc pair collision resolver pipeline.
// Pipeline: three front stages, a 32-stage square root, a FRAC_BITS+1 stage divider
// and six back stages lie between start and done.
// Throughput: one beat per cycle; busy is always low and results leave as a strobe
// on done, with no back-pressure from the receiver.
// Reset: arst_n clears all valid bits and loads disc_radius = 1.0, bounce_factor = 1.0.
module particle_pair_collision_resolve_unit #(
	parameter int FRAC_BITS = ppcr_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ppcr_pkg::pair_t             pair,
	output logic                        done,
	output ppcr_pkg::result_t           result,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [ppcr_pkg::RAD_W-1:0]  cfg_data
);
	localparam int SEP_W = ppcr_pkg::SEP_W;
	localparam int NW    = FRAC_BITS + 2;          // signed unit normal component
	localparam int CP_W  = NW + SEP_W;              // normal * push
	localparam int CX_W  = CP_W - FRAC_BITS;
	localparam int DV_W  = 33;                      // velocity difference
	localparam int VP_W  = DV_W + NW + 1;           // dot product sum
	localparam int VN_W  = VP_W - FRAC_BITS;
	localparam int IM_W  = VN_W + 18;               // |vn| * (1 + e)
	localparam int IP_W  = VN_W + 2 + NW;           // impulse * normal
	localparam int IX_W  = IP_W - FRAC_BITS;
	localparam logic [63:0] DIST_FLOOR = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
	localparam logic [63:0] RND        = (64'd1 << FRAC_BITS) - 64'd1;

	// ---------------- configuration ----------------
	logic [ppcr_pkg::RAD_W-1:0] radius_q;
	logic [ppcr_pkg::BNC_W-1:0] bounce_q;
	logic [SEP_W-1:0]           sep;
	logic [2*SEP_W-1:0]         sepsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= ppcr_pkg::RAD_W'(65536);
			bounce_q <= ppcr_pkg::BOUNCE_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppcr_pkg::CFG_RADIUS: radius_q <= cfg_data;
				ppcr_pkg::CFG_BOUNCE: bounce_q <= cfg_data[ppcr_pkg::BNC_W-1:0];
				default:              radius_q <= radius_q;
			endcase
		end
	end

	assign sep = {radius_q, 1'b0};

	// Squared separation; config only changes while the pipe is empty is a rule for the user, not enforced here.
	always_ff @(posedge clk) begin
		sepsq_q <= sep * sep;
	end

	assign busy = 1'b0;

	// ---------------- S1: differences ----------------
	logic                   vld_s1;
	ppcr_pkg::pair_t        pair_s1;
	logic signed [32:0]     dx_s1, dy_s1, dvx_s1, dvy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		pair_s1 <= pair;
		dx_s1   <= 33'(pair.first_pos_x) - 33'(pair.second_pos_x);
		dy_s1   <= 33'(pair.first_pos_y) - 33'(pair.second_pos_y);
		dvx_s1  <= 33'(pair.first_vel_x) - 33'(pair.second_vel_x);
		dvy_s1  <= 33'(pair.first_vel_y) - 33'(pair.second_vel_y);
	end

	// ---------------- S2: box test and squares ----------------
	logic [32:0]          adx, ady;
	logic                 vld_s2, near_s2, sgx_s2, sgy_s2;
	ppcr_pkg::pair_t      pair_s2;
	logic signed [32:0]   dvx_s2, dvy_s2;
	logic [SEP_W-1:0]     adx_s2, ady_s2;
	logic [2*SEP_W-1:0]   sqx_s2, sqy_s2;

	assign adx = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign ady = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	// Inside the box the distances fit SEP_W bits, so squares stay narrow.
	always_ff @(posedge clk) begin
		near_s2 <= (adx < 33'(sep)) && (ady < 33'(sep));
		sgx_s2  <= dx_s1[32];
		sgy_s2  <= dy_s1[32];
		pair_s2 <= pair_s1;
		dvx_s2  <= dvx_s1;
		dvy_s2  <= dvy_s1;
		adx_s2  <= adx[SEP_W-1:0];
		ady_s2  <= ady[SEP_W-1:0];
		sqx_s2  <= adx[SEP_W-1:0] * adx[SEP_W-1:0];
		sqy_s2  <= ady[SEP_W-1:0] * ady[SEP_W-1:0];
	end

	// ---------------- S3: squared distance and overlap ----------------
	typedef struct packed {
		ppcr_pkg::pair_t     pair;
		logic                hit;
		logic signed [32:0]  dvx;
		logic signed [32:0]  dvy;
		logic                sgx;
		logic                sgy;
		logic [SEP_W-1:0]    adx;
		logic [SEP_W-1:0]    ady;
	} sq_side_t;

	logic [ppcr_pkg::SQ_IN_W-1:0] dsq;
	logic [ppcr_pkg::SQ_IN_W-1:0] dsq_s3;
	logic                         vld_s3;
	sq_side_t                     side_s3;

	assign dsq = ppcr_pkg::SQ_IN_W'(sqx_s2) + ppcr_pkg::SQ_IN_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		dsq_s3       <= dsq;
		side_s3.pair <= pair_s2;
		side_s3.hit  <= near_s2 && (64'(dsq) < 64'(sepsq_q)) && (64'(dsq) > DIST_FLOOR);
		side_s3.dvx  <= dvx_s2;
		side_s3.dvy  <= dvy_s2;
		side_s3.sgx  <= sgx_s2;
		side_s3.sgy  <= sgy_s2;
		side_s3.adx  <= adx_s2;
		side_s3.ady  <= ady_s2;
	end

	// ---------------- square root ----------------
	logic             sq_vld;
	logic [SEP_W-1:0] dlen;
	sq_side_t         sq_side;

	ppcr_sqrt #(
		.SIDE_W ($bits(sq_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.radicand (dsq_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.root     (dlen),
		.out_side (sq_side)
	);

	// ---------------- normal: divider ----------------
	typedef struct packed {
		ppcr_pkg::pair_t     pair;
		logic                hit;
		logic signed [32:0]  dvx;
		logic signed [32:0]  dvy;
		logic                sgx;
		logic                sgy;
		logic [SEP_W-2:0]    push;
	} dv_side_t;

	logic [SEP_W-1:0] gap;
	dv_side_t         dv_in, dv_out;
	logic             dv_vld;
	logic [FRAC_BITS:0] qx, qy;

	// Overlap, halved into push rounding down; dlen < sep whenever hit.
	assign gap = sep - dlen;

	always_comb begin
		dv_in.pair = sq_side.pair;
		dv_in.hit  = sq_side.hit;
		dv_in.dvx  = sq_side.dvx;
		dv_in.dvy  = sq_side.dvy;
		dv_in.sgx  = sq_side.sgx;
		dv_in.sgy  = sq_side.sgy;
		dv_in.push = gap[SEP_W-1:1];
	end

	ppcr_div #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    ($bits(dv_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.num_x    (sq_side.adx),
		.num_y    (sq_side.ady),
		.den      (dlen),
		.in_side  (dv_in),
		.out_vld  (dv_vld),
		.quo_x    (qx),
		.quo_y    (qy),
		.out_side (dv_out)
	);

	// ---------------- S4: signed normal, products ----------------
	logic signed [NW-1:0]   nx, ny;
	logic                   vld_s4, hit_s4;
	ppcr_pkg::pair_t        pair_s4;
	logic signed [NW-1:0]   nx_s4, ny_s4;
	logic signed [CP_W-1:0] cpx_s4, cpy_s4;
	logic signed [DV_W+NW-1:0] vpx_s4, vpy_s4;

	assign nx = dv_out.sgx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign ny = dv_out.sgy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		hit_s4  <= dv_out.hit;
		pair_s4 <= dv_out.pair;
		nx_s4   <= nx;
		ny_s4   <= ny;
		cpx_s4  <= nx * $signed({1'b0, dv_out.push});
		cpy_s4  <= ny * $signed({1'b0, dv_out.push});
		vpx_s4  <= dv_out.dvx * nx;
		vpy_s4  <= dv_out.dvy * ny;
	end

	// ---------------- S5: scale back, truncating toward zero ----------------
	logic signed [CP_W-1:0] cpx_adj, cpy_adj;
	logic signed [VP_W-1:0] vsum, vadj;
	logic                   vld_s5, hit_s5;
	ppcr_pkg::pair_t        pair_s5;
	logic signed [NW-1:0]   nx_s5, ny_s5;
	logic signed [CX_W-1:0] cx_s5, cy_s5;
	logic signed [VN_W-1:0] vn_s5;

	assign cpx_adj = cpx_s4 + (cpx_s4[CP_W-1] ? CP_W'(RND) : '0);
	assign cpy_adj = cpy_s4 + (cpy_s4[CP_W-1] ? CP_W'(RND) : '0);
	assign vsum    = VP_W'(vpx_s4) + VP_W'(vpy_s4);
	assign vadj    = vsum + (vsum[VP_W-1] ? VP_W'(RND) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		hit_s5  <= hit_s4;
		pair_s5 <= pair_s4;
		nx_s5   <= nx_s4;
		ny_s5   <= ny_s4;
		cx_s5   <= CX_W'(cpx_adj >>> FRAC_BITS);
		cy_s5   <= CX_W'(cpy_adj >>> FRAC_BITS);
		vn_s5   <= VN_W'(vadj >>> FRAC_BITS);
	end

	// ---------------- S6: corrected positions, impulse magnitude ----------------
	logic [ppcr_pkg::BNC_W-1:0] e_clamp;
	logic [17:0]                bfac;
	logic [VN_W-1:0]            vmag;
	ppcr_pkg::pair_t            pos_fix;
	logic                       vld_s6, hit_s6, bnc_s6;
	ppcr_pkg::pair_t            pair_s6;
	logic signed [NW-1:0]       nx_s6, ny_s6;
	logic [IM_W-1:0]            impp_s6;

	assign e_clamp = (bounce_q > ppcr_pkg::BOUNCE_ONE) ? ppcr_pkg::BOUNCE_ONE : bounce_q;
	assign bfac    = 18'(ppcr_pkg::BOUNCE_ONE) + 18'(e_clamp);
	assign vmag    = VN_W'(-vn_s5);

	// positions move apart only on overlap
	always_comb begin
		pos_fix = pair_s5;
		if (hit_s5) begin
			pos_fix.first_pos_x  = ppcr_pkg::sat32(64'(pair_s5.first_pos_x) + 64'(cx_s5));
			pos_fix.first_pos_y  = ppcr_pkg::sat32(64'(pair_s5.first_pos_y) + 64'(cy_s5));
			pos_fix.second_pos_x = ppcr_pkg::sat32(64'(pair_s5.second_pos_x) - 64'(cx_s5));
			pos_fix.second_pos_y = ppcr_pkg::sat32(64'(pair_s5.second_pos_y) - 64'(cy_s5));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		hit_s6  <= hit_s5;
		bnc_s6  <= hit_s5 && vn_s5[VN_W-1];
		nx_s6   <= nx_s5;
		ny_s6   <= ny_s5;
		impp_s6 <= vmag * bfac;
		pair_s6 <= pos_fix;
	end

	// ---------------- S7: impulse along the normal ----------------
	logic [VN_W:0]          imp;
	logic                   vld_s7, hit_s7, bnc_s7;
	ppcr_pkg::pair_t        pair_s7;
	logic signed [IP_W-1:0] ipx_s7, ipy_s7;

	assign imp = impp_s6[IM_W-1:17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		hit_s7  <= hit_s6;
		bnc_s7  <= bnc_s6;
		pair_s7 <= pair_s6;
		ipx_s7  <= $signed({1'b0, imp}) * nx_s6;
		ipy_s7  <= $signed({1'b0, imp}) * ny_s6;
	end

	// ---------------- S8: truncate impulse ----------------
	logic signed [IP_W-1:0] ipx_adj, ipy_adj;
	logic                   vld_s8, hit_s8, bnc_s8;
	ppcr_pkg::pair_t        pair_s8;
	logic signed [IX_W-1:0] ix_s8, iy_s8;

	assign ipx_adj = ipx_s7 + (ipx_s7[IP_W-1] ? IP_W'(RND) : '0);
	assign ipy_adj = ipy_s7 + (ipy_s7[IP_W-1] ? IP_W'(RND) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		hit_s8  <= hit_s7;
		bnc_s8  <= bnc_s7;
		pair_s8 <= pair_s7;
		ix_s8   <= IX_W'(ipx_adj >>> FRAC_BITS);
		iy_s8   <= IX_W'(ipy_adj >>> FRAC_BITS);
	end

	// ---------------- S9: output register ----------------
	logic              done_q;
	ppcr_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vld_s8;
	end

	always_ff @(posedge clk) begin
		result_q.new_first_pos_x  <= pair_s8.first_pos_x;
		result_q.new_first_pos_y  <= pair_s8.first_pos_y;
		result_q.new_second_pos_x <= pair_s8.second_pos_x;
		result_q.new_second_pos_y <= pair_s8.second_pos_y;
		result_q.overlapped       <= hit_s8;
		result_q.bounced          <= bnc_s8;
		if (bnc_s8) begin
			result_q.new_first_vel_x  <= ppcr_pkg::sat32(64'(pair_s8.first_vel_x) + 64'(ix_s8));
			result_q.new_first_vel_y  <= ppcr_pkg::sat32(64'(pair_s8.first_vel_y) + 64'(iy_s8));
			result_q.new_second_vel_x <= ppcr_pkg::sat32(64'(pair_s8.second_vel_x) - 64'(ix_s8));
			result_q.new_second_vel_y <= ppcr_pkg::sat32(64'(pair_s8.second_vel_y) - 64'(iy_s8));
		end else begin
			result_q.new_first_vel_x  <= pair_s8.first_vel_x;
			result_q.new_first_vel_y  <= pair_s8.first_vel_y;
			result_q.new_second_vel_x <= pair_s8.second_vel_x;
			result_q.new_second_vel_y <= pair_s8.second_vel_y;
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule
